### src/atbm_pkg.sv
// Package for the angle template matcher: sizes, derived widths, status codes
// and the request/response words of the shared divider.
// Used by the top level and the divider; depends on nothing.
`timescale 1ns / 1ps

package atbm_pkg;

    // Capacity of the template store.
    localparam int MAX_TEMPLATES = 64;
    localparam int MAX_GROUPS    = 8;
    localparam int MAX_ANGLES    = 32;

    // Widths that follow from the capacity.
    localparam int TW      = $clog2(MAX_TEMPLATES);      // template index
    localparam int TCNT_W  = $clog2(MAX_TEMPLATES + 1);  // template count
    localparam int GW      = $clog2(MAX_GROUPS);         // group index
    localparam int GCNT_W  = $clog2(MAX_GROUPS + 1);     // group count
    localparam int AW      = $clog2(MAX_ANGLES);         // angle position
    localparam int SIZE_W  = $clog2(MAX_ANGLES + 1);     // group size
    localparam int COUNT_W = $clog2(MAX_ANGLES * MAX_ANGLES + 1);
    localparam int FRAC_W  = 16;
    localparam int DIVD_W  = COUNT_W + FRAC_W;           // dividend and sum
    localparam int DIVS_W  = SIZE_W;                     // divisor
    localparam int DCNT_W  = $clog2(DIVD_W + 1);

    // Field widths.
    localparam int ANGLE_W = 10;
    localparam int ID_W    = 16;
    localparam int SCORE_W = 22;
    localparam int THR_W   = 10;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);
    localparam logic [ID_W-1:0]  NO_MATCH_ID     = ID_W'(1000);

    // Result status codes.
    localparam logic [1:0] STAT_STORED = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ANSWER = 2'd2;

    // Request type codes.
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

### src/angle_template_best_match.sv
// Top level of the angle template matcher: build buffer, template store,
// scoring sequencer. Depends on atbm_pkg, atbm_ram and atbm_div.
`timescale 1ns / 1ps

// Usage
// A word is taken when start is high and busy is low. Words build one
// template (angle groups of angles) in a buffer; the word with item_last
// closes it and req_type of that word says store or query. Words without
// item_last are taken one per cycle, back to back, and give no result. A
// closing word that starts a store copy or a query raises busy until its
// result is shown: done is high for one cycle with status, best_id,
// best_score and truncated; the receiver cannot stall, and these four hold
// until the next result.
// A store copies the buffer memory into the template memory one angle per
// cycle. A full table or a query against an empty table is answered
// without raising busy. A query walks every template, every group of it
// and every pair of query and template angles; an empty template or a
// group with an empty side is skipped. The pair loop reads one template
// angle per cycle and each score waits on the divider. The threshold
// register is written through cfg_valid/cfg_data, always ready. Reset
// empties the table, clears the build buffer and sets threshold to 4.

module angle_template_best_match (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic signed [atbm_pkg::ANGLE_W-1:0] angle,
    input  logic                         angle_valid,
    input  logic                         group_end,
    input  logic                         item_last,
    input  logic [atbm_pkg::ID_W-1:0]    record_id,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [atbm_pkg::THR_W-1:0]   cfg_data,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [atbm_pkg::ID_W-1:0]    best_id,
    output logic [atbm_pkg::SCORE_W-1:0] best_score,
    output logic                         truncated
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_COPY, ST_SFIN, ST_TRD, ST_TCHK, ST_GRD, ST_GCHK,
        ST_QRD, ST_PAIR, ST_DRAIN, ST_DIV1, ST_DIV1W, ST_DIV2, ST_DIV2W
    } state_t;

    localparam int KW   = atbm_pkg::GW + atbm_pkg::AW;
    localparam int QAW  = KW;
    localparam int TAW  = atbm_pkg::TW + KW;
    localparam int SZAW = atbm_pkg::TW + atbm_pkg::GW;
    localparam int INFO_W = atbm_pkg::GCNT_W + atbm_pkg::ID_W;

    state_t                          state_reg;
    logic [atbm_pkg::THR_W-1:0]      thr_reg;
    logic [atbm_pkg::GCNT_W-1:0]     grp_reg;
    logic [atbm_pkg::SIZE_W-1:0]     pos_reg;
    logic                            trunc_reg;
    logic [atbm_pkg::SIZE_W-1:0]     qsize_reg [atbm_pkg::MAX_GROUPS];
    logic [atbm_pkg::TCNT_W-1:0]     count_reg;
    logic [atbm_pkg::GCNT_W-1:0]     ng_reg;
    logic [atbm_pkg::ID_W-1:0]       id_reg;
    logic [KW-1:0]                   k_reg;
    logic [KW-1:0]                   kprev_reg;
    logic                            cp_en_reg;
    logic [atbm_pkg::TW-1:0]         t_reg;
    logic [atbm_pkg::GW-1:0]         g_reg;
    logic [atbm_pkg::AW-1:0]         i_reg;
    logic [atbm_pkg::AW-1:0]         j_reg;
    logic [atbm_pkg::COUNT_W-1:0]    cnt_reg;
    logic                            cmp_en_reg;
    logic [atbm_pkg::DIVD_W-1:0]     sum_reg;
    logic [atbm_pkg::SCORE_W-1:0]    best_reg;
    logic [atbm_pkg::ID_W-1:0]       bestid_reg;
    logic                            done_reg;
    logic [1:0]                      status_reg;
    logic [atbm_pkg::ID_W-1:0]       best_id_reg;
    logic [atbm_pkg::SCORE_W-1:0]    best_score_reg;
    logic                            truncated_reg;

    // Memory ports.
    logic                            q_we;
    logic [QAW-1:0]                  q_addr;
    logic [atbm_pkg::ANGLE_W-1:0]    q_rdata;
    logic                            t_we;
    logic [TAW-1:0]                  t_addr;
    logic [atbm_pkg::ANGLE_W-1:0]    t_rdata;
    logic                            sz_we;
    logic [SZAW-1:0]                 sz_addr;
    logic [atbm_pkg::SIZE_W-1:0]     sz_wdata;
    logic [atbm_pkg::SIZE_W-1:0]     sz_rdata;
    logic                            inf_we;
    logic [atbm_pkg::TW-1:0]         inf_addr;
    logic [INFO_W-1:0]               inf_wdata;
    logic [INFO_W-1:0]               inf_rdata;

    atbm_pkg::div_req_t              div_req;
    atbm_pkg::div_rsp_t              div_rsp;

    // Word acceptance and the build buffer's next values.
    logic                            accept;
    logic                            room;
    logic                            put;
    logic [atbm_pkg::SIZE_W-1:0]     pos_a;
    logic                            close;
    logic [atbm_pkg::GCNT_W-1:0]     grp_n;
    logic [atbm_pkg::SIZE_W-1:0]     pos_n;
    logic                            trunc_n;
    logic                            table_full;

    always_comb
    begin
        accept  = start && !busy;
        room    = (grp_reg < atbm_pkg::GCNT_W'(atbm_pkg::MAX_GROUPS)) &&
                  (pos_reg < atbm_pkg::SIZE_W'(atbm_pkg::MAX_ANGLES));
        put     = angle_valid && room;
        pos_a   = put ? pos_reg + 1'b1 : pos_reg;
        trunc_n = trunc_reg || (angle_valid && !room);
        close   = group_end || (item_last && (pos_a != '0));
        grp_n   = grp_reg;
        pos_n   = pos_a;
        if (close)
        begin
            if (grp_reg < atbm_pkg::GCNT_W'(atbm_pkg::MAX_GROUPS))
            begin
                grp_n = grp_reg + 1'b1;
                pos_n = '0;
            end
            else
            begin
                trunc_n = 1'b1;
            end
        end
        table_full = count_reg >= atbm_pkg::TCNT_W'(atbm_pkg::MAX_TEMPLATES);
    end

    // Scoring helpers.
    logic [atbm_pkg::SIZE_W-1:0]     qs;
    logic [atbm_pkg::SIZE_W-1:0]     rs;
    logic [atbm_pkg::SIZE_W-1:0]     mx;
    logic [atbm_pkg::GCNT_W-1:0]     gc;
    logic [atbm_pkg::ID_W-1:0]       tid;
    logic signed [atbm_pkg::ANGLE_W:0] diff;
    logic [atbm_pkg::ANGLE_W:0]      absd;
    logic                            hit;
    logic                            last_group;
    logic                            last_tmpl;
    logic                            last_copy;
    logic [atbm_pkg::SCORE_W-1:0]    score;
    logic                            win;

    always_comb
    begin
        qs         = qsize_reg[g_reg];
        rs         = sz_rdata;
        mx         = (qs > rs) ? qs : rs;
        gc         = inf_rdata[INFO_W-1:atbm_pkg::ID_W];
        tid        = inf_rdata[atbm_pkg::ID_W-1:0];
        diff       = $signed({q_rdata[atbm_pkg::ANGLE_W-1], q_rdata}) -
                     $signed({t_rdata[atbm_pkg::ANGLE_W-1], t_rdata});
        absd       = diff[atbm_pkg::ANGLE_W] ? $unsigned(-diff) : $unsigned(diff);
        hit        = absd < {1'b0, thr_reg};
        last_group = (atbm_pkg::GCNT_W'(g_reg) + 1'b1) == gc;
        last_tmpl  = (atbm_pkg::TCNT_W'(t_reg) + 1'b1) == count_reg;
        last_copy  = ((atbm_pkg::GCNT_W'(k_reg[KW-1:atbm_pkg::AW]) + 1'b1) == ng_reg) &&
                     (k_reg[atbm_pkg::AW-1:0] == '1);
        score      = div_rsp.quotient[atbm_pkg::SCORE_W-1:0];
        win        = score > best_reg;
    end

    // Memory address and write selection.
    always_comb
    begin
        q_we   = accept && put;
        if (q_we)
        begin
            q_addr = {grp_reg[atbm_pkg::GW-1:0], pos_reg[atbm_pkg::AW-1:0]};
        end
        else if (state_reg == ST_COPY)
        begin
            q_addr = k_reg;
        end
        else
        begin
            q_addr = {g_reg, i_reg};
        end

        t_we   = cp_en_reg;
        t_addr = t_we ? {count_reg[atbm_pkg::TW-1:0], kprev_reg} : {t_reg, g_reg, j_reg};

        sz_we    = (state_reg == ST_COPY) && (k_reg[atbm_pkg::AW-1:0] == '0);
        sz_addr  = sz_we ? {count_reg[atbm_pkg::TW-1:0], k_reg[KW-1:atbm_pkg::AW]}
                         : {t_reg, g_reg};
        sz_wdata = qsize_reg[k_reg[KW-1:atbm_pkg::AW]];

        inf_we    = (state_reg == ST_SFIN);
        inf_addr  = inf_we ? count_reg[atbm_pkg::TW-1:0] : t_reg;
        inf_wdata = {ng_reg, id_reg};
    end

    // Divider requests: one per group score, one per template score.
    always_comb
    begin
        div_req.start    = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);
        div_req.dividend = (state_reg == ST_DIV1) ?
                           {cnt_reg, atbm_pkg::FRAC_W'(0)} : sum_reg;
        div_req.divisor  = (state_reg == ST_DIV1) ? mx : atbm_pkg::DIVS_W'(gc);
    end

    atbm_ram #(.WIDTH(atbm_pkg::ANGLE_W), .DEPTH(atbm_pkg::MAX_GROUPS * atbm_pkg::MAX_ANGLES))
    u_qmem (.clk(clk), .we(q_we), .addr(q_addr), .wdata(angle), .rdata(q_rdata));

    atbm_ram #(.WIDTH(atbm_pkg::ANGLE_W),
               .DEPTH(atbm_pkg::MAX_TEMPLATES * atbm_pkg::MAX_GROUPS * atbm_pkg::MAX_ANGLES))
    u_tmem (.clk(clk), .we(t_we), .addr(t_addr), .wdata(q_rdata), .rdata(t_rdata));

    atbm_ram #(.WIDTH(atbm_pkg::SIZE_W), .DEPTH(atbm_pkg::MAX_TEMPLATES * atbm_pkg::MAX_GROUPS))
    u_szmem (.clk(clk), .we(sz_we), .addr(sz_addr), .wdata(sz_wdata), .rdata(sz_rdata));

    atbm_ram #(.WIDTH(INFO_W), .DEPTH(atbm_pkg::MAX_TEMPLATES))
    u_infmem (.clk(clk), .we(inf_we), .addr(inf_addr), .wdata(inf_wdata), .rdata(inf_rdata));

    atbm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // Sequencer: build, store copy, and the template/group/pair walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= atbm_pkg::THRESHOLD_RESET;
            grp_reg        <= '0;
            pos_reg        <= '0;
            trunc_reg      <= 1'b0;
            for (int n = 0; n < atbm_pkg::MAX_GROUPS; n++)
            begin
                qsize_reg[n] <= '0;
            end
            count_reg      <= '0;
            cp_en_reg      <= 1'b0;
            cmp_en_reg     <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= atbm_pkg::STAT_STORED;
            best_id_reg    <= '0;
            best_score_reg <= '0;
            truncated_reg  <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            cp_en_reg  <= 1'b0;
            cmp_en_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end

            // Pair compare, in the cycle after the template angle read.
            if (cmp_en_reg && hit)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (put)
                        begin
                            qsize_reg[grp_reg[atbm_pkg::GW-1:0]] <= pos_a;
                        end
                        grp_reg   <= grp_n;
                        pos_reg   <= pos_n;
                        trunc_reg <= trunc_n;
                        ng_reg    <= grp_n;
                        id_reg    <= record_id;
                        if (item_last)
                        begin
                            if ((req_type == atbm_pkg::REQ_STORE && table_full) ||
                                (req_type == atbm_pkg::REQ_QUERY && count_reg == '0))
                            begin
                                // Answered at once; the buffer returns to reset.
                                done_reg       <= 1'b1;
                                status_reg     <= (req_type == atbm_pkg::REQ_STORE) ?
                                                  atbm_pkg::STAT_FULL : atbm_pkg::STAT_ANSWER;
                                best_id_reg    <= (req_type == atbm_pkg::REQ_STORE) ?
                                                  '0 : atbm_pkg::NO_MATCH_ID;
                                best_score_reg <= '0;
                                truncated_reg  <= trunc_n;
                                grp_reg        <= '0;
                                pos_reg        <= '0;
                                trunc_reg      <= 1'b0;
                                for (int n = 0; n < atbm_pkg::MAX_GROUPS; n++)
                                begin
                                    qsize_reg[n] <= '0;
                                end
                            end
                            else if (req_type == atbm_pkg::REQ_STORE)
                            begin
                                k_reg     <= '0;
                                state_reg <= (grp_n == '0) ? ST_SFIN : ST_COPY;
                            end
                            else
                            begin
                                t_reg      <= '0;
                                best_reg   <= '0;
                                bestid_reg <= atbm_pkg::NO_MATCH_ID;
                                state_reg  <= ST_TRD;
                            end
                        end
                    end
                end

                ST_COPY:
                begin
                    cp_en_reg <= 1'b1;
                    kprev_reg <= k_reg;
                    k_reg     <= k_reg + 1'b1;
                    if (last_copy)
                    begin
                        state_reg <= ST_SFIN;
                    end
                end

                ST_SFIN:
                begin
                    count_reg      <= count_reg + 1'b1;
                    done_reg       <= 1'b1;
                    status_reg     <= atbm_pkg::STAT_STORED;
                    best_id_reg    <= '0;
                    best_score_reg <= '0;
                    truncated_reg  <= trunc_reg;
                    grp_reg        <= '0;
                    pos_reg        <= '0;
                    trunc_reg      <= 1'b0;
                    for (int n = 0; n < atbm_pkg::MAX_GROUPS; n++)
                    begin
                        qsize_reg[n] <= '0;
                    end
                    state_reg      <= ST_IDLE;
                end

                ST_TRD:
                begin
                    state_reg <= ST_TCHK;
                end

                ST_TCHK:
                begin
                    if (gc == '0)
                    begin
                        // Empty template scores zero and never wins.
                        if (last_tmpl)
                        begin
                            done_reg       <= 1'b1;
                            status_reg     <= atbm_pkg::STAT_ANSWER;
                            best_id_reg    <= bestid_reg;
                            best_score_reg <= best_reg;
                            truncated_reg  <= trunc_reg;
                            grp_reg        <= '0;
                            pos_reg        <= '0;
                            trunc_reg      <= 1'b0;
                            for (int n = 0; n < atbm_pkg::MAX_GROUPS; n++)
                            begin
                                qsize_reg[n] <= '0;
                            end
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            t_reg     <= t_reg + 1'b1;
                            state_reg <= ST_TRD;
                        end
                    end
                    else
                    begin
                        g_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_GRD;
                    end
                end

                ST_GRD:
                begin
                    state_reg <= ST_GCHK;
                end

                ST_GCHK:
                begin
                    if (rs == '0 || qs == '0)
                    begin
                        // A group with either side empty adds nothing.
                        if (last_group)
                        begin
                            state_reg <= ST_DIV2;
                        end
                        else
                        begin
                            g_reg     <= g_reg + 1'b1;
                            state_reg <= ST_GRD;
                        end
                    end
                    else
                    begin
                        i_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_QRD;
                    end
                end

                ST_QRD:
                begin
                    j_reg     <= '0;
                    state_reg <= ST_PAIR;
                end

                ST_PAIR:
                begin
                    cmp_en_reg <= 1'b1;
                    j_reg      <= j_reg + 1'b1;
                    if ((atbm_pkg::SIZE_W'(j_reg) + 1'b1) == rs)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end

                ST_DRAIN:
                begin
                    if ((atbm_pkg::SIZE_W'(i_reg) + 1'b1) == qs)
                    begin
                        state_reg <= ST_DIV1;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_QRD;
                    end
                end

                ST_DIV1:
                begin
                    state_reg <= ST_DIV1W;
                end

                ST_DIV1W:
                begin
                    if (div_rsp.done)
                    begin
                        sum_reg <= sum_reg + div_rsp.quotient;
                        if (last_group)
                        begin
                            state_reg <= ST_DIV2;
                        end
                        else
                        begin
                            g_reg     <= g_reg + 1'b1;
                            state_reg <= ST_GRD;
                        end
                    end
                end

                ST_DIV2:
                begin
                    state_reg <= ST_DIV2W;
                end

                ST_DIV2W:
                begin
                    if (div_rsp.done)
                    begin
                        if (win)
                        begin
                            best_reg   <= score;
                            bestid_reg <= tid;
                        end
                        if (last_tmpl)
                        begin
                            done_reg       <= 1'b1;
                            status_reg     <= atbm_pkg::STAT_ANSWER;
                            best_id_reg    <= win ? tid : bestid_reg;
                            best_score_reg <= win ? score : best_reg;
                            truncated_reg  <= trunc_reg;
                            grp_reg        <= '0;
                            pos_reg        <= '0;
                            trunc_reg      <= 1'b0;
                            for (int n = 0; n < atbm_pkg::MAX_GROUPS; n++)
                            begin
                                qsize_reg[n] <= '0;
                            end
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            t_reg     <= t_reg + 1'b1;
                            state_reg <= ST_TRD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign status     = status_reg;
    assign best_id    = best_id_reg;
    assign best_score = best_score_reg;
    assign truncated  = truncated_reg;

    // A result is only shown once the block is free for the next word.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result shown while busy");

    // A store into a full table is refused on the next cycle.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_last && req_type == atbm_pkg::REQ_STORE && table_full)
        |=> (done && status == atbm_pkg::STAT_FULL && $stable(count_reg)))
        else $error("full table store not refused");

    // A query with no positive score reports the no-match id.
    a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == atbm_pkg::STAT_ANSWER && best_score == '0)
        |-> best_id == atbm_pkg::NO_MATCH_ID)
        else $error("zero score without no-match id");

    // A divider start is never directly followed by another start or by done.
    a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_req.start && !div_rsp.done)
        else $error("divider restarted");

endmodule

### src/atbm_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module atbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed entry; the read register takes its old value.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### src/atbm_div.sv
// Restoring divider, one quotient bit per cycle, shared by the group and
// template score divisions. Depends on atbm_pkg.
`timescale 1ns / 1ps

module atbm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  atbm_pkg::div_req_t req,
    output atbm_pkg::div_rsp_t rsp
);

    logic                        run_reg;
    logic [atbm_pkg::DCNT_W-1:0] cnt_reg;
    logic [atbm_pkg::DIVS_W-1:0] rem_reg;
    logic [atbm_pkg::DIVD_W-1:0] quo_reg;
    logic [atbm_pkg::DIVS_W-1:0] dvs_reg;
    logic                        done_reg;
    logic [atbm_pkg::DIVS_W:0]   trial;
    logic                        fits;

    // One trial subtraction of the shifted remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[atbm_pkg::DIVD_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= atbm_pkg::DCNT_W'(atbm_pkg::DIVD_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == atbm_pkg::DCNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, then shift one bit in per cycle.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= atbm_pkg::DIVS_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[atbm_pkg::DIVS_W-1:0];
            end
            quo_reg <= {quo_reg[atbm_pkg::DIVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
